FILE: rtl/ascon_m2_pkg.sv
// Shared types, constants and the round function of the two-share masked Ascon permutation.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ascon_m2_pkg;

	localparam int unsigned SHARE_ROT = 11;
	localparam logic [3:0] NUM_ROUNDS = 4'd12;
	localparam logic [3:0] RC_HIGH_BASE = 4'hF;

	typedef struct packed {
		logic [4:0][63:0] a;
		logic [4:0][63:0] b;
		logic [63:0]      rnd;
	} state_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic xfer;
	} cmd_t;

	function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
		logic [63:0] r;
		r = (x >> (n % 64)) | (x << ((64 - (n % 64)) % 64));
		if ((n % 64) == 0) begin
			r = x;
		end
		return r;
	endfunction

	function automatic logic [63:0] to_b(input logic [63:0] x);
		return rotr64(x, SHARE_ROT);
	endfunction

	function automatic logic [63:0] from_b(input logic [63:0] x);
		return rotr64(x, 64 - (SHARE_ROT % 64));
	endfunction

	function automatic logic [63:0] diffuse(input logic [63:0] x, input int unsigned r1,
			input int unsigned r2);
		return x ^ rotr64(x, r1) ^ rotr64(x, r2);
	endfunction

	// One round: constant addition, masked chi with the random word as a third
	// share, and the linear layer on both shares. Share a of word 2 is kept
	// inverted across rounds, so the inverted constant is added here.
	function automatic state_t round_f(input state_t s, input logic [3:0] r);
		logic [4:0][63:0] ta;
		logic [4:0][63:0] tb;
		logic [4:0][63:0] na;
		logic [4:0][63:0] nb;
		logic [63:0]      rc;
		logic [63:0]      ra;
		logic [63:0]      rb;
		state_t           o;
		rc = {56'd0, RC_HIGH_BASE - r, r};
		ta = s.a;
		tb = s.b;
		ta[2] = ta[2] ^ ~rc;
		ta[0] = ta[0] ^ ta[4];
		ta[4] = ta[4] ^ ta[3];
		ta[2] = ta[2] ^ ta[1];
		tb[0] = tb[0] ^ tb[4];
		tb[4] = tb[4] ^ tb[3];
		tb[2] = tb[2] ^ tb[1];
		// Fresh share from the random word.
		ra = s.rnd;
		rb = to_b(s.rnd);
		ra = ra ^ (~ta[0] & from_b(tb[1])) ^ (~ta[0] & ta[1]);
		rb = rb ^ (tb[0] & tb[1]) ^ (tb[0] & to_b(ta[1]));
		for (int k = 0; k < 5; k++) begin
			na[k] = ta[k] ^ (~ta[(k + 1) % 5] & from_b(tb[(k + 2) % 5]))
				^ (~ta[(k + 1) % 5] & ta[(k + 2) % 5]);
			nb[k] = tb[k] ^ (tb[(k + 1) % 5] & tb[(k + 2) % 5])
				^ (tb[(k + 1) % 5] & to_b(ta[(k + 2) % 5]));
		end
		// Word 4 takes the random share instead of the plain chi term.
		na[4] = ta[4] ^ ra;
		nb[4] = tb[4] ^ rb;
		na[1] = na[1] ^ na[0];
		na[0] = na[0] ^ na[4];
		na[3] = na[3] ^ na[2];
		nb[1] = nb[1] ^ nb[0];
		nb[0] = nb[0] ^ nb[4];
		nb[3] = nb[3] ^ nb[2];
		o.a[0] = diffuse(na[0], 19, 28);
		o.b[0] = diffuse(nb[0], 19, 28);
		o.a[1] = diffuse(na[1], 61, 39);
		o.b[1] = diffuse(nb[1], 61, 39);
		o.a[2] = diffuse(na[2], 1, 6);
		o.b[2] = diffuse(nb[2], 1, 6);
		o.a[3] = diffuse(na[3], 10, 17);
		o.b[3] = diffuse(nb[3], 10, 17);
		o.a[4] = diffuse(na[4], 7, 41);
		o.b[4] = diffuse(nb[4], 7, 41);
		o.rnd = rotr64(ra, 13);
		return o;
	endfunction

endpackage

FILE: rtl/ascon_m2_ctrl.sv
// Controller of the masked Ascon permutation: handshakes and round sequencing.
// Depends on ascon_m2_pkg; drives the datapath with load, step and transfer commands.
module ascon_m2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              done,
	output ascon_m2_pkg::cmd_t cmd
);

	ascon_m2_pkg::ctrl_state_t state_q;
	ascon_m2_pkg::ctrl_state_t state_d;
	logic                      out_valid_q;
	logic                      can_xfer;

	assign in_ready  = (state_q == ascon_m2_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign can_xfer  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.xfer = 1'b0;
		unique case (state_q)
			ascon_m2_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ascon_m2_pkg::ST_RUN;
				end
			end
			ascon_m2_pkg::ST_RUN: begin
				if (!done) begin
					cmd.step = 1'b1;
				end else if (can_xfer) begin
					cmd.xfer = 1'b1;
					state_d  = ascon_m2_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ascon_m2_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ascon_m2_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/ascon_m2_datapath.sv
// Datapath of the masked Ascon permutation: working state, round counter, output register.
// Depends on ascon_m2_pkg for the state type and the round function.
module ascon_m2_datapath (
	input  logic                 clk,
	input  ascon_m2_pkg::cmd_t   cmd,
	input  ascon_m2_pkg::state_t in_state,
	input  logic [3:0]           start_round,
	output logic                 done,
	output ascon_m2_pkg::state_t out_state
);

	ascon_m2_pkg::state_t work_q;
	ascon_m2_pkg::state_t out_q;
	logic [3:0]           round_q;
	ascon_m2_pkg::state_t load_state;
	ascon_m2_pkg::state_t final_state;

	assign done      = (round_q >= ascon_m2_pkg::NUM_ROUNDS);
	assign out_state = out_q;

	// Share a of word 2 stays inverted while the rounds run.
	always_comb begin
		load_state       = in_state;
		load_state.a[2]  = ~in_state.a[2];
		final_state      = work_q;
		final_state.a[2] = ~work_q.a[2];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q  <= load_state;
			round_q <= start_round;
		end else if (cmd.step) begin
			work_q  <= ascon_m2_pkg::round_f(work_q, round_q);
			round_q <= round_q + 4'd1;
		end
		if (cmd.xfer) begin
			out_q <= final_state;
		end
	end

endmodule

FILE: rtl/ascon_masked_two_share_permutation.sv
// Two-share masked Ascon permutation, rounds start_round..11, one round per clock cycle.
// out_valid rises after the load, the rounds and the move of the finished state into the
// output register, which waits while an earlier result is held; a start round of 12 or more
// skips the rounds. Having one round unit, the block takes the next input beat only after that move.
// Reset (arst_n low) empties the block: no item in flight and no result pending.
module ascon_masked_two_share_permutation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] in_w0_a,
	input  logic [63:0] in_w0_b,
	input  logic [63:0] in_w1_a,
	input  logic [63:0] in_w1_b,
	input  logic [63:0] in_w2_a,
	input  logic [63:0] in_w2_b,
	input  logic [63:0] in_w3_a,
	input  logic [63:0] in_w3_b,
	input  logic [63:0] in_w4_a,
	input  logic [63:0] in_w4_b,
	input  logic [63:0] random_in,
	input  logic [3:0]  start_round,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_w0_a,
	output logic [63:0] out_w0_b,
	output logic [63:0] out_w1_a,
	output logic [63:0] out_w1_b,
	output logic [63:0] out_w2_a,
	output logic [63:0] out_w2_b,
	output logic [63:0] out_w3_a,
	output logic [63:0] out_w3_b,
	output logic [63:0] out_w4_a,
	output logic [63:0] out_w4_b,
	output logic [63:0] random_out
);

	// The input beat is gathered into one state record. Share b of every word is
	// kept in its rotated form throughout; the round function converts between the rotated and
	// plain forms only where share-a or random terms meet share-b terms inside the masked S-box.
	ascon_m2_pkg::state_t in_state;
	ascon_m2_pkg::state_t out_state;
	ascon_m2_pkg::cmd_t   cmd;
	logic                 done;

	assign in_state.a[0] = in_w0_a;
	assign in_state.b[0] = in_w0_b;
	assign in_state.a[1] = in_w1_a;
	assign in_state.b[1] = in_w1_b;
	assign in_state.a[2] = in_w2_a;
	assign in_state.b[2] = in_w2_b;
	assign in_state.a[3] = in_w3_a;
	assign in_state.b[3] = in_w3_b;
	assign in_state.a[4] = in_w4_a;
	assign in_state.b[4] = in_w4_b;
	assign in_state.rnd  = random_in;

	// The controller loads the datapath on an input beat, steps one round per cycle
	// until the round counter is at least twelve, and then moves the finished state into
	// the output register as soon as that register is empty or being emptied. A
	// result waiting on out_ready therefore does not block the rounds of the next item.
	ascon_m2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.done      (done),
		.cmd       (cmd)
	);

	ascon_m2_datapath u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.in_state    (in_state),
		.start_round (start_round),
		.done        (done),
		.out_state   (out_state)
	);

	assign out_w0_a   = out_state.a[0];
	assign out_w0_b   = out_state.b[0];
	assign out_w1_a   = out_state.a[1];
	assign out_w1_b   = out_state.b[1];
	assign out_w2_a   = out_state.a[2];
	assign out_w2_b   = out_state.b[2];
	assign out_w3_a   = out_state.a[3];
	assign out_w3_b   = out_state.b[3];
	assign out_w4_a   = out_state.a[4];
	assign out_w4_b   = out_state.b[4];
	assign random_out = out_state.rnd;

endmodule
